FILE: hw/rtl/pls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

    localparam int PLS_CAPACITY = 128;
    localparam int PLS_DATA_W   = 32;

    localparam logic [2:0] FN_APPEND = 3'd0;
    localparam logic [2:0] FN_INSERT = 3'd1;
    localparam logic [2:0] FN_DELETE = 3'd2;
    localparam logic [2:0] FN_ADD    = 3'd3;
    localparam logic [2:0] FN_READ   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADPOS  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_PRESENT = 2'd3;

    typedef struct packed {
        logic [2:0]                   func;
        logic [7:0]                   position;
        logic signed [PLS_DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]                   status;
        logic signed [PLS_DATA_W-1:0] data;
        logic [7:0]                   count;
    } t_rsp;

endpackage

`default_nettype wire

FILE: hw/rtl/pls_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/pls_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module pls_seq import pls_pkg::*; #(
    parameter int CAPACITY = PLS_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  t_req                        i_req,
    output logic                        o_done,
    output t_rsp                        o_rsp,
    output logic                        o_ram_we,
    output logic [$clog2(CAPACITY)-1:0] o_ram_waddr,
    output logic [PLS_DATA_W-1:0]       o_ram_wdata,
    output logic                        o_ram_re,
    output logic [$clog2(CAPACITY)-1:0] o_ram_raddr,
    input  logic [PLS_DATA_W-1:0]       i_ram_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > 8) ? LW : 8) + 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PUT} t_state;

    t_state                r_state, n_state;
    logic [LW-1:0]         r_len, n_len;
    logic [2:0]            r_op, n_op;
    logic [PLS_DATA_W-1:0] r_val, n_val;
    logic [AW-1:0]         r_pos_a, n_pos_a;
    logic [AW-1:0]         r_addr, n_addr;
    logic [AW-1:0]         r_end, n_end;
    logic                  r_down, n_down;
    logic                  r_issue, n_issue;
    logic                  r_rd_vld, n_rd_vld;
    logic [AW-1:0]         r_rd_tag, n_rd_tag;
    logic                  r_rd_last, n_rd_last;
    logic                  r_found, n_found;
    logic [PLS_DATA_W-1:0] r_data, n_data;
    logic                  r_done, n_done;
    t_rsp                  r_rsp, n_rsp;

    logic [CW-1:0] pos_x;
    logic [CW-1:0] len_x;
    logic          pos_zero;
    logic          bad_ins;
    logic          bad_acc;
    logic          ins_tail;
    logic          full;
    logic [AW-1:0] pos_a_in;
    logic [AW-1:0] len_a;
    logic [AW-1:0] lenm1_a;
    logic          hit;

    assign pos_x    = CW'(i_req.position);
    assign len_x    = CW'(r_len);
    assign pos_zero = (i_req.position == 8'd0);
    assign bad_ins  = pos_zero || (pos_x > (len_x + CW'(1)));
    assign bad_acc  = pos_zero || (pos_x > len_x);
    assign ins_tail = (pos_x == (len_x + CW'(1)));
    assign full     = (r_len == LW'(CAPACITY));
    assign pos_a_in = AW'(pos_x - CW'(1));
    assign len_a    = AW'(r_len);
    assign lenm1_a  = AW'(r_len - LW'(1));
    assign hit      = r_found || (i_ram_rdata == r_val);

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_op      = r_op;
        n_val     = r_val;
        n_pos_a   = r_pos_a;
        n_addr    = r_addr;
        n_end     = r_end;
        n_down    = r_down;
        n_issue   = r_issue;
        n_rd_vld  = r_rd_vld;
        n_rd_tag  = r_rd_tag;
        n_rd_last = r_rd_last;
        n_found   = r_found;
        n_data    = r_data;
        n_done    = 1'b0;
        n_rsp     = r_rsp;

        o_ram_we    = 1'b0;
        o_ram_waddr = len_a;
        o_ram_wdata = i_req.value;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_addr;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op        = i_req.func;
                    n_val       = i_req.value;
                    n_pos_a     = pos_a_in;
                    n_found     = 1'b0;
                    n_done      = 1'b1;
                    n_rsp.data  = '0;
                    n_rsp.status = ST_OK;
                    unique case (i_req.func)
                        FN_APPEND: begin
                            if (full) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                o_ram_we = 1'b1;
                                n_len    = r_len + LW'(1);
                            end
                        end
                        FN_INSERT: begin
                            if (bad_ins) begin
                                n_rsp.status = ST_BADPOS;
                            end else if (full) begin
                                n_rsp.status = ST_FULL;
                            end else if (ins_tail) begin
                                o_ram_we = 1'b1;
                                n_len    = r_len + LW'(1);
                            end else begin
                                // shift the tail up, last entry first
                                n_done  = 1'b0;
                                n_addr  = lenm1_a;
                                n_end   = pos_a_in;
                                n_down  = 1'b1;
                                n_issue = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        FN_DELETE: begin
                            if (bad_acc) begin
                                n_rsp.status = ST_BADPOS;
                            end else begin
                                n_done  = 1'b0;
                                n_addr  = pos_a_in;
                                n_end   = lenm1_a;
                                n_down  = 1'b0;
                                n_issue = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        FN_ADD: begin
                            if (r_len == LW'(0)) begin
                                o_ram_we = 1'b1;
                                n_len    = r_len + LW'(1);
                            end else begin
                                n_done  = 1'b0;
                                n_addr  = '0;
                                n_end   = lenm1_a;
                                n_down  = 1'b0;
                                n_issue = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        FN_READ: begin
                            if (bad_acc) begin
                                n_rsp.status = ST_BADPOS;
                            end else begin
                                n_done  = 1'b0;
                                n_addr  = pos_a_in;
                                n_end   = pos_a_in;
                                n_down  = 1'b0;
                                n_issue = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_rsp.status = ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                o_ram_re = r_issue;
                if (r_issue) begin
                    if (r_addr == r_end) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_down ? (r_addr - AW'(1)) : (r_addr + AW'(1));
                    end
                end
                n_rd_vld  = r_issue;
                n_rd_tag  = r_addr;
                n_rd_last = r_issue && (r_addr == r_end);

                if (r_rd_vld) begin
                    case (r_op)
                        FN_INSERT: begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_rd_tag + AW'(1);
                            o_ram_wdata = i_ram_rdata;
                            if (r_rd_last) begin
                                n_state = S_PUT;
                            end
                        end
                        FN_DELETE: begin
                            if (r_rd_tag == r_pos_a) begin
                                n_data = i_ram_rdata;
                            end else begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = r_rd_tag - AW'(1);
                                o_ram_wdata = i_ram_rdata;
                            end
                            if (r_rd_last) begin
                                n_len        = r_len - LW'(1);
                                n_done       = 1'b1;
                                n_rsp.status = ST_OK;
                                n_rsp.data   = (r_rd_tag == r_pos_a) ? i_ram_rdata : r_data;
                                n_state      = S_IDLE;
                            end
                        end
                        FN_ADD: begin
                            n_found = hit;
                            if (r_rd_last) begin
                                n_done     = 1'b1;
                                n_rsp.data = '0;
                                n_state    = S_IDLE;
                                if (hit) begin
                                    n_rsp.status = ST_PRESENT;
                                end else if (full) begin
                                    n_rsp.status = ST_FULL;
                                end else begin
                                    o_ram_we     = 1'b1;
                                    o_ram_waddr  = len_a;
                                    o_ram_wdata  = r_val;
                                    n_len        = r_len + LW'(1);
                                    n_rsp.status = ST_OK;
                                end
                            end
                        end
                        default: begin
                            if (r_rd_last) begin
                                n_done       = 1'b1;
                                n_rsp.status = ST_OK;
                                n_rsp.data   = i_ram_rdata;
                                n_state      = S_IDLE;
                            end
                        end
                    endcase
                end
            end

            S_PUT: begin
                // drop the new value into the gap left by the shift
                o_ram_we     = 1'b1;
                o_ram_waddr  = r_pos_a;
                o_ram_wdata  = r_val;
                n_len        = r_len + LW'(1);
                n_done       = 1'b1;
                n_rsp.status = ST_OK;
                n_rsp.data   = '0;
                n_state      = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rsp.count = 8'(n_len);
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_val     <= n_val;
        r_pos_a   <= n_pos_a;
        r_addr    <= n_addr;
        r_end     <= n_end;
        r_down    <= n_down;
        r_rd_tag  <= n_rd_tag;
        r_rd_last <= n_rd_last;
        r_found   <= n_found;
        r_data    <= n_data;
        r_rsp     <= n_rsp;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_issue  <= n_issue;
            r_rd_vld <= n_rd_vld;
            r_done   <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_store_top.sv
// Append, tail insert, add-if-absent to an empty list, bad positions, a full store on
// append or insert and unused codes strobe the result in the cycle after acceptance.
// Read fetches one entry; delete shifts the entries after p down; other inserts shift
// the tail up and then write the gap; add-if-absent reads every entry before it answers.
// busy is high while these run and low in the strobe cycle, when a new request may start.
// The receiver cannot stall. Synchronous reset empties the list and leaves memory as it is.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store_top import pls_pkg::*; #(
    parameter int CAPACITY = PLS_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [PLS_DATA_W-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [PLS_DATA_W-1:0] ram_rdata;

    pls_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    pls_ram #(
        .WIDTH (PLS_DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // every accepted request either answers at once or holds busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("accepted request neither answered nor busy");

    a_busy_ends_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("busy dropped without a result strobe");

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_done)
        else $error("result strobe while a request is still in progress");

endmodule

`default_nettype wire

FILE: sim/list_store_checker.sv
`timescale 1ns / 1ps

module list_store_checker import pls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_req i_req,
    input  logic i_done,
    input  t_rsp i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_list_count,
    output int   o_checked,
    output int   o_full_hits
);

    logic signed [PLS_DATA_W-1:0] shadow_list [PLS_CAPACITY];
    int   list_len;
    int   err_cnt;
    int   checked_cnt;
    int   full_cnt;
    t_rsp awaited_rsp [$];

    // Apply one request to the shadow list and return the response it should produce.
    function automatic t_rsp list_apply(input t_req r);
        t_rsp rsp;
        int   pos;
        int   idx;
        logic found;
        rsp   = '0;
        pos   = int'(r.position);
        found = 1'b0;
        case (r.func)
            FN_APPEND: begin
                if (list_len >= PLS_CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    shadow_list[list_len] = r.value;
                    list_len++;
                end
            end
            FN_INSERT: begin
                if (pos < 1 || pos > list_len + 1) begin
                    rsp.status = ST_BADPOS;
                end else if (list_len >= PLS_CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (idx = list_len; idx >= pos; idx--)
                        shadow_list[idx] = shadow_list[idx - 1];
                    shadow_list[pos - 1] = r.value;
                    list_len++;
                end
            end
            FN_DELETE: begin
                if (pos < 1 || pos > list_len) begin
                    rsp.status = ST_BADPOS;
                end else begin
                    rsp.data = shadow_list[pos - 1];
                    for (idx = pos - 1; idx + 1 < list_len; idx++)
                        shadow_list[idx] = shadow_list[idx + 1];
                    list_len--;
                end
            end
            FN_ADD: begin
                // search first: a match wins over a full store
                for (idx = 0; idx < list_len; idx++)
                    if (shadow_list[idx] == r.value)
                        found = 1'b1;
                if (found) begin
                    rsp.status = ST_PRESENT;
                end else if (list_len >= PLS_CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    shadow_list[list_len] = r.value;
                    list_len++;
                end
            end
            FN_READ: begin
                if (pos < 1 || pos > list_len)
                    rsp.status = ST_BADPOS;
                else
                    rsp.data = shadow_list[pos - 1];
            end
            default: begin
            end
        endcase
        rsp.count = 8'(list_len);
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp pred;
        if (!i_rst_n) begin
            list_len = 0;
            awaited_rsp.delete();
        end else begin
            // retire the finished request before taking on a new one in the same cycle
            if (i_done) begin
                if (awaited_rsp.size() == 0) begin
                    err_cnt++;
                    $display("%0t: response with no request outstanding: status %0d data %0d count %0d",
                             $time, i_rsp.status, i_rsp.data, i_rsp.count);
                end else begin
                    want = awaited_rsp.pop_front();
                    checked_cnt++;
                    if (i_rsp.status !== want.status) begin
                        err_cnt++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, i_rsp.status);
                    end
                    if (i_rsp.data !== want.data) begin
                        err_cnt++;
                        $display("%0t: data mismatch: expected %0d, actual %0d",
                                 $time, want.data, i_rsp.data);
                    end
                    if (i_rsp.count !== want.count) begin
                        err_cnt++;
                        $display("%0t: count mismatch: expected %0d, actual %0d",
                                 $time, want.count, i_rsp.count);
                    end
                end
            end
            if (i_start && !i_busy) begin
                pred = list_apply(i_req);
                if (pred.status == ST_FULL)
                    full_cnt++;
                awaited_rsp.push_back(pred);
            end
        end
        o_errors     <= err_cnt;
        o_pending    <= awaited_rsp.size();
        o_list_count <= list_len;
        o_checked    <= checked_cnt;
        o_full_hits  <= full_cnt;
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pls_pkg::*;

    localparam int         ITEM_COUNT   = 550;
    localparam int         TAIL_ITEMS   = 60;
    localparam int         CYCLE_LIMIT  = 500000;
    localparam int         DRAIN_CYCLES = PLS_CAPACITY + 8;
    localparam logic [2:0] FN_UNUSED_LO = 3'd5;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req req     = '0;
    logic busy;
    logic done;
    t_rsp rsp;

    int errors;
    int pending;
    int list_count;
    int checked;
    int full_hits;
    int sent_cnt;
    int ignored_cnt;

    positional_list_store_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (req),
        .o_done  (done),
        .o_rsp   (rsp)
    );

    list_store_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req),
        .i_done       (done),
        .i_rsp        (rsp),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_list_count (list_count),
        .o_checked    (checked),
        .o_full_hits  (full_hits)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Present a request and hold it until the block takes it.
    task automatic send_request(input logic [2:0] fn, input logic [7:0] pos,
                                input logic signed [PLS_DATA_W-1:0] val);
        req   <= '{func: fn, position: pos, value: val};
        start <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sent_cnt++;
        if (fn >= FN_UNUSED_LO)
            ignored_cnt++;
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Small pool and extremes give repeats for add-if-absent; the rest is full range.
    function automatic logic signed [PLS_DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7fff_ffff;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // Mostly valid positions up to hi, with the ends, zero and out-of-range ones mixed in.
    function automatic logic [7:0] pick_position(input int hi);
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return 8'd0;
        if (roll == 1)
            return 8'($urandom_range(0, 255));
        if (roll < 4)
            return 8'(hi + $urandom_range(1, 3));
        if (hi < 1)
            return 8'd1;
        if (roll < 8)
            return $urandom_range(0, 1) ? 8'd1 : 8'(hi);
        return 8'($urandom_range(1, hi));
    endfunction

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles with %0d responses outstanding", CYCLE_LIMIT, pending);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int   counted;
        int   roll;
        int   full_dwell;
        int   cur;
        logic growing;
        logic paused;

        counted    = 0;
        full_dwell = 0;
        growing    = 1'b1;
        paused     = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: every position is bad
        send_request(FN_READ,   8'd1, 32'sd0);
        send_request(FN_DELETE, 8'd1, 32'sd0);
        send_request(FN_INSERT, 8'd0, 32'sd5);
        send_request(FN_INSERT, 8'd2, 32'sd5);
        send_request(FN_APPEND, 8'd0, 32'sh7fff_ffff);
        send_request(FN_APPEND, 8'd0, 32'sh8000_0000);
        send_request(FN_INSERT, 8'd1, -32'sd1);
        send_request(FN_INSERT, 8'd4, 32'sd0);
        send_request(FN_INSERT, 8'd2, 32'sh5555_5555);
        send_request(FN_ADD,    8'd0, 32'sd0);
        send_request(FN_ADD,    8'd0, 32'shaaaa_aaaa);
        send_request(FN_READ,   8'd0, 32'sd0);
        send_request(FN_READ,   8'd1, 32'sd0);
        send_request(FN_READ,   8'd6, 32'sd0);
        send_request(FN_READ,   8'd7, 32'sd0);
        send_request(FN_READ,   8'd255, 32'sd0);
        send_request(FN_DELETE, 8'd3, 32'sd0);
        send_request(FN_DELETE, 8'd5, 32'sd0);
        send_request(FN_DELETE, 8'd1, 32'sd0);
        send_request(FN_DELETE, 8'd4, 32'sd0);
        send_request(FN_UNUSED_LO,        8'd1, 32'sd9);
        send_request(FN_UNUSED_LO + 3'd1, 8'd2, 32'sd9);
        send_request(FN_UNUSED_LO + 3'd2, 8'd3, 32'sd9);
        send_request(FN_INSERT, 8'd4, 32'sd12345);
        send_request(FN_ADD,    8'd0, 32'sh8000_0000);

        // alternate between filling the store to capacity and draining it to four entries or fewer
        while (counted < ITEM_COUNT) begin
            cur = list_count;
            if (cur >= PLS_CAPACITY)
                full_dwell++;
            if (growing && full_dwell >= 14) begin
                growing    = 1'b0;
                full_dwell = 0;
            end else if (!growing && cur <= 4) begin
                growing = 1'b1;
            end

            if (!paused && counted >= ITEM_COUNT / 2) begin
                paused = 1'b1;
                wait_drained();
            end else if (counted < ITEM_COUNT - TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
                idle_gap($urandom_range(1, 5));
            end

            roll = $urandom_range(0, 99);
            if (growing) begin
                if (roll < 35)
                    send_request(FN_APPEND, 8'($urandom()), pick_value());
                else if (roll < 65)
                    send_request(FN_INSERT, pick_position(cur + 1), pick_value());
                else if (roll < 85)
                    send_request(FN_ADD, 8'($urandom()), pick_value());
                else if (roll < 92)
                    send_request(FN_READ, pick_position(cur), pick_value());
                else if (roll < 97)
                    send_request(FN_DELETE, pick_position(cur), pick_value());
                else
                    send_request(FN_UNUSED_LO + 3'($urandom_range(0, 2)),
                                 8'($urandom()), pick_value());
            end else begin
                if (roll < 45)
                    send_request(FN_DELETE, pick_position(cur), pick_value());
                else if (roll < 65)
                    send_request(FN_READ, pick_position(cur), pick_value());
                else if (roll < 75)
                    send_request(FN_APPEND, 8'($urandom()), pick_value());
                else if (roll < 82)
                    send_request(FN_INSERT, pick_position(cur + 1), pick_value());
                else if (roll < 90)
                    send_request(FN_ADD, 8'($urandom()), pick_value());
                else
                    send_request(FN_UNUSED_LO + 3'($urandom_range(0, 2)),
                                 8'($urandom()), pick_value());
            end
            if (roll < 97 || !growing && roll < 90)
                counted++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Issued %0d requests (%0d with unused codes), compared %0d responses,",
                 sent_cnt, ignored_cnt, checked);
        $display("%0d of them store-full rejections across fill and drain phases", full_hits);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
